/* rtl/nbh_pkg.sv */
`default_nettype none

package nbh_pkg;

    // default coordinate width, signed Q(W-9).8
    localparam int COORD_WIDTH_DEF = 24;
    // decouple queue depth, power of two, at least 4
    localparam int QUEUE_DEPTH_DEF = 4;
    // fraction bits of the fixed point format, and 1.0 in that format
    localparam int FRAC_BITS = 8;
    localparam int ONE_Q8    = 1 << FRAC_BITS;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_EYE_EAST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EYE_LEVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EYE_DEPTH = 2'd2;

endpackage

`default_nettype wire

/* rtl/nbh_if.sv */
`default_nettype none

interface nbh_box_if #(
    parameter int W = nbh_pkg::COORD_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] box_min_x;
    logic signed [W-1:0] box_max_x;
    logic signed [W-1:0] box_min_y;
    logic signed [W-1:0] box_max_y;
    logic signed [W-1:0] surface_height;
    logic                last_box;

    modport source (
        output valid, box_min_x, box_max_x, box_min_y, box_max_y,
               surface_height, last_box,
        input  ready
    );
    modport sink (
        input  valid, box_min_x, box_max_x, box_min_y, box_max_y,
               surface_height, last_box,
        output ready
    );
endinterface

interface nbh_res_if #(
    parameter int W = nbh_pkg::COORD_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] mirror_height;
    logic                any_found;

    modport source (output valid, mirror_height, any_found, input ready);
    modport sink (input valid, mirror_height, any_found, output ready);
endinterface

interface nbh_cfg_if #(
    parameter int W = nbh_pkg::COORD_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic [nbh_pkg::CFG_IDX_W-1:0] index;
    logic [W-1:0]                 data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/nbh_front.sv */
`default_nettype none

module nbh_front #(
    parameter int W     = nbh_pkg::COORD_WIDTH_DEF,
    parameter int DEPTH = nbh_pkg::QUEUE_DEPTH_DEF,
    localparam int FREE_W = $clog2(DEPTH + 1),
    localparam int SQ_W   = 2 * W + 2,
    localparam int QW     = 2 * SQ_W + W + 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    nbh_box_if.sink                i_box,
    input  wire logic [W-1:0]      i_eye_east,
    input  wire logic [W-1:0]      i_eye_level,
    input  wire logic [W-1:0]      i_eye_depth,
    input  wire logic [FREE_W-1:0] i_free,
    output logic                   o_push,
    output logic [QW-1:0]          o_push_data
);

    localparam int EW = W + 2;

    logic                  accept;
    logic [FREE_W-1:0]     inflight;
    logic signed [EW-1:0]  ex, ey;
    logic signed [EW-1:0]  gx_a, gx_b, gy_a, gy_b, gx, gy;
    logic signed [W:0]     h_ext, lvl_lim;

    logic                  r1_valid, r1_qual, r1_last;
    logic [W:0]            r1_gx, r1_gy;
    logic [W-1:0]          r1_h;
    logic                  r2_valid, r2_qual, r2_last;
    logic [SQ_W-1:0]       r2_sq_x, r2_sq_y;
    logic [W-1:0]          r2_h;

    // reserve a queue slot for every word already in the pipe
    assign inflight    = FREE_W'(r1_valid) + FREE_W'(r2_valid);
    assign i_box.ready = i_free > inflight;
    assign accept      = i_box.valid && i_box.ready;

    always_comb begin
        ex   = EW'(signed'(i_eye_east));
        ey   = -EW'(signed'(i_eye_depth));
        gx_a = EW'(i_box.box_min_x) - ex;
        gx_b = ex - EW'(i_box.box_max_x);
        gy_a = EW'(i_box.box_min_y) - ey;
        gy_b = ey - EW'(i_box.box_max_y);
        gx   = '0;
        if (gx_a > gx) begin
            gx = gx_a;
        end
        if (gx_b > gx) begin
            gx = gx_b;
        end
        gy = '0;
        if (gy_a > gy) begin
            gy = gy_a;
        end
        if (gy_b > gy) begin
            gy = gy_b;
        end
        h_ext   = (W+1)'(i_box.surface_height);
        lvl_lim = (W+1)'(signed'(i_eye_level)) + (W+1)'(nbh_pkg::ONE_Q8);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            r1_valid <= accept;
            r2_valid <= r1_valid;
        end
    end

    // stage 1: gaps and skip test; stage 2: squares
    always_ff @(posedge i_clk) begin
        r1_gx   <= gx[W:0];
        r1_gy   <= gy[W:0];
        r1_h    <= i_box.surface_height;
        r1_qual <= h_ext <= lvl_lim;
        r1_last <= i_box.last_box;
        r2_sq_x <= SQ_W'(r1_gx) * SQ_W'(r1_gx);
        r2_sq_y <= SQ_W'(r1_gy) * SQ_W'(r1_gy);
        r2_h    <= r1_h;
        r2_qual <= r1_qual;
        r2_last <= r1_last;
    end

    assign o_push      = r2_valid;
    assign o_push_data = {r2_sq_x, r2_sq_y, r2_h, r2_qual, r2_last};

endmodule

`default_nettype wire

/* rtl/nbh_queue.sv */
`default_nettype none

module nbh_queue #(
    parameter int QW    = 8,
    parameter int DEPTH = nbh_pkg::QUEUE_DEPTH_DEF,
    localparam int FREE_W = $clog2(DEPTH + 1),
    localparam int AW     = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [QW-1:0]     i_push_data,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output logic [QW-1:0]          o_data,
    output logic [FREE_W-1:0]      o_free
);

    logic [QW-1:0]     r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [FREE_W-1:0] r_count;
    logic              do_pop;

    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_free  = FREE_W'(DEPTH) - r_count;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + FREE_W'(1);
                2'b01:   r_count <= r_count - FREE_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/nbh_back.sv */
`default_nettype none

module nbh_back #(
    parameter int W = nbh_pkg::COORD_WIDTH_DEF,
    localparam int SQ_W = 2 * W + 2,
    localparam int QW   = 2 * SQ_W + W + 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [QW-1:0] i_data,
    output logic               o_pop,
    nbh_res_if.source          o_res
);

    logic [SQ_W-1:0]     sq_x, sq_y, dist_sq;
    logic signed [W-1:0] h;
    logic                qual, last, upd;

    logic [SQ_W-1:0]     r_best_dist;
    logic signed [W-1:0] r_best_h;
    logic                r_have;
    logic                r_out_valid;
    logic signed [W-1:0] r_out_h;
    logic                r_out_found;

    assign {sq_x, sq_y, h, qual, last} = i_data;
    assign dist_sq = sq_x + sq_y;

    // a last word needs the output slot free or draining
    assign o_pop = i_valid && (!last || !r_out_valid || o_res.ready);

    assign upd = qual && (!r_have || dist_sq < r_best_dist
                          || (dist_sq == r_best_dist && h > r_best_h));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_best_dist <= '0;
            r_best_h    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && last) begin
                r_have      <= 1'b0;
                r_best_dist <= '0;
                r_best_h    <= '0;
                r_out_valid <= 1'b1;
            end else begin
                if (o_pop && upd) begin
                    r_have      <= 1'b1;
                    r_best_dist <= dist_sq;
                    r_best_h    <= h;
                end
                if (o_res.ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && last) begin
            r_out_h     <= upd ? h : (r_have ? r_best_h : '0);
            r_out_found <= upd || r_have;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.mirror_height = r_out_h;
    assign o_res.any_found     = r_out_found;

endmodule

`default_nettype wire

/* rtl/nearest_box_height_select.sv */
`default_nettype none

// Nearest water surface height selector. Takes one rectangle word per clock
// on i_box while ready is high and, on the word flagged last_box, returns
// one word on o_res with the surface height of the rectangle nearest to the
// eye (ties go to the higher surface; rectangles more than 1.0 above
// eye_level are skipped), or zero with any_found low when nothing qualified.
// The front computes the per-axis gaps and their squares in two register
// stages, a small queue (QUEUE_DEPTH words, power of two, at least 4)
// decouples it from the back, which adds the squares and compares against
// the running best combinationally. Sustained rate is one rectangle per
// cycle while o_res is not stalled; a run's result is registered once its
// last word leaves the queue. Eye registers are written through i_cfg, which
// is always ready; write them only while no run is in flight.
module nearest_box_height_select #(
    parameter int COORD_WIDTH = nbh_pkg::COORD_WIDTH_DEF,
    parameter int QUEUE_DEPTH = nbh_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    nbh_box_if.sink   i_box,
    nbh_cfg_if.sink   i_cfg,
    nbh_res_if.source o_res
);

    localparam int W      = COORD_WIDTH;
    localparam int FREE_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SQ_W   = 2 * W + 2;
    localparam int QW     = 2 * SQ_W + W + 2;

    logic [W-1:0]      r_eye_east, r_eye_level, r_eye_depth;
    logic [FREE_W-1:0] q_free;
    logic              push, pop, q_valid;
    logic [QW-1:0]     push_data, q_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye_east  <= '0;
            r_eye_level <= '0;
            r_eye_depth <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                nbh_pkg::CFG_EYE_EAST:  r_eye_east  <= i_cfg.data;
                nbh_pkg::CFG_EYE_LEVEL: r_eye_level <= i_cfg.data;
                nbh_pkg::CFG_EYE_DEPTH: r_eye_depth <= i_cfg.data;
                default: ; // unknown index: drop the write
            endcase
        end
    end

    nbh_front #(
        .W     (W),
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_box       (i_box),
        .i_eye_east  (r_eye_east),
        .i_eye_level (r_eye_level),
        .i_eye_depth (r_eye_depth),
        .i_free      (q_free),
        .o_push      (push),
        .o_push_data (push_data)
    );

    nbh_queue #(
        .QW    (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_valid     (q_valid),
        .o_data      (q_data),
        .o_free      (q_free)
    );

    nbh_back #(
        .W (W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_data  (q_data),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire
